// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked implication checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/mis_pkg.sv =====
// ----------------------------------------------------------------------------
// mis_pkg
// Shared constants and types for the modular inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package mis_pkg;

  // Default operand width
  localparam int DATA_WIDTH_DEF = 16;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_MODULUS = 2'd0;

  // Modulus after reset
  localparam int MODULUS_RESET = 26;

  // Status from the shared divide-step unit to the sequencer
  typedef struct packed {
    logic can_sub;    // shifted divisor fits in the partial remainder
    logic can_shift;  // divisor doubled still fits
  } step_flags_t;

endpackage

`default_nettype wire

// ===== sv/mis_step_unit.sv =====
// ----------------------------------------------------------------------------
// mis_step_unit
// Shared compare/subtract unit: one restoring-division step on the partial
// remainder, with the matching update of the Bezout coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_step_unit import mis_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic [DATA_WIDTH-1:0]        rem,
  input  wire logic [DATA_WIDTH-1:0]        dsh,
  input  wire logic signed [DATA_WIDTH+1:0] tacc,
  input  wire logic signed [DATA_WIDTH+1:0] tsh,
  output step_flags_t                       flags,
  output logic [DATA_WIDTH-1:0]             rem_sub,
  output logic signed [DATA_WIDTH+1:0]      t_sub
);

  always_comb begin
    flags.can_sub   = (dsh <= rem);
    flags.can_shift = ({dsh, 1'b0} <= {1'b0, rem});
    rem_sub         = rem - dsh;
    t_sub           = tacc - tsh;
  end

endmodule

`default_nettype wire

// ===== sv/mis_cfg.sv =====
// ----------------------------------------------------------------------------
// mis_cfg
// APB register slice holding the modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_cfg import mis_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  output logic [DATA_WIDTH-1:0]      modulus
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr == ADDR_MODULUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= DATA_WIDTH'(MODULUS_RESET);
    end else if (wr_en) begin
      modulus <= pwdata[DATA_WIDTH-1:0];
    end
  end

  assign prdata = (paddr == ADDR_MODULUS) ? APB_DATA_W'(modulus) : '0;

endmodule

`default_nettype wire

// ===== sv/mis_core.sv =====
// ----------------------------------------------------------------------------
// mis_core
// Sequencer for the reduction and the extended Euclid loop around the shared
// divide-step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_core import mis_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [DATA_WIDTH-1:0] a_value,
  input  wire logic [DATA_WIDTH-1:0]        modulus,
  output logic                              busy,
  output logic                              done,
  output logic [DATA_WIDTH-1:0]             inverse,
  output logic                              found
);

  localparam int W  = DATA_WIDTH;
  localparam int TW = DATA_WIDTH + 2;
  localparam int KW = $clog2(DATA_WIDTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALIGN = 4'd1;
  localparam logic [3:0] S_SUB   = 4'd2;
  localparam logic [3:0] S_FIX   = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  logic [3:0]           state;
  logic [W-1:0]         m_r;
  logic                 neg;
  logic                 red;
  logic [W-1:0]         r0;
  logic [W-1:0]         r1;
  logic [W-1:0]         rem;
  logic [W-1:0]         dsh;
  logic signed [TW-1:0] t0;
  logic signed [TW-1:0] t1;
  logic signed [TW-1:0] tacc;
  logic signed [TW-1:0] tsh;
  logic [KW-1:0]        k;

  step_flags_t          flags;
  logic [W-1:0]         rem_sub;
  logic signed [TW-1:0] t_sub;

  logic [W-1:0]         a_raw;
  logic [W-1:0]         mag;
  logic signed [TW-1:0] m_ext;
  logic signed [TW-1:0] t_fold;

  mis_step_unit #(.DATA_WIDTH(DATA_WIDTH)) u_step (
    .rem     (rem),
    .dsh     (dsh),
    .tacc    (tacc),
    .tsh     (tsh),
    .flags   (flags),
    .rem_sub (rem_sub),
    .t_sub   (t_sub)
  );

  assign a_raw  = a_value;
  assign mag    = a_raw[W-1] ? (~a_raw + {{(W-1){1'b0}}, 1'b1}) : a_raw;
  assign m_ext  = $signed({2'b00, m_r});
  assign t_fold = t0[TW-1] ? (t0 + m_ext) : t0;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= (modulus < W'(2)) ? S_DONE : S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (!flags.can_shift) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (k == '0) begin
            state <= red ? S_FIX : S_FIN;
          end
        end
        S_FIX:   state <= S_CHECK;
        S_CHECK: state <= (r1 == '0) ? S_DONE : S_ALIGN;
        S_FIN:   state <= S_CHECK;
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          m_r     <= modulus;
          neg     <= a_raw[W-1];
          red     <= 1'b1;
          rem     <= mag;
          dsh     <= modulus;
          tacc    <= '0;
          tsh     <= '0;
          k       <= '0;
          inverse <= '0;
          found   <= 1'b0;
        end
      end
      S_ALIGN: begin
        if (flags.can_shift) begin
          dsh <= {dsh[W-2:0], 1'b0};
          tsh <= tsh <<< 1;
          k   <= k + KW'(1);
        end
      end
      S_SUB: begin
        if (flags.can_sub) begin
          rem  <= rem_sub;
          tacc <= t_sub;
        end
        if (k != '0) begin
          dsh <= dsh >> 1;
          tsh <= tsh >>> 1;
          k   <= k - KW'(1);
        end
      end
      S_FIX: begin
        r0 <= m_r;
        r1 <= (neg && (rem != '0)) ? (m_r - rem) : rem;
        t0 <= '0;
        t1 <= {{(TW-1){1'b0}}, 1'b1};
      end
      S_CHECK: begin
        if (r1 == '0) begin
          if (r0 == {{(W-1){1'b0}}, 1'b1}) begin
            inverse <= t_fold[W-1:0];
            found   <= 1'b1;
          end
        end else begin
          red  <= 1'b0;
          rem  <= r0;
          dsh  <= r1;
          tacc <= t0;
          tsh  <= t1;
          k    <= '0;
        end
      end
      S_FIN: begin
        r0 <= r1;
        r1 <= rem;
        t0 <= t1;
        t1 <= tacc;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/modular_inverse_search.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_search
// Modular multiplicative inverse of a signed value by extended Euclid.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in a_value; busy then stays high
// until the answer is out. The value is first reduced into 0 .. modulus-1
// (a negative value gives a non-negative remainder), then the extended
// Euclidean algorithm runs on (modulus, value). One result beat follows each
// accepted value: done is high for exactly one cycle with inverse and found
// valid, and the receiver cannot stall it, so capture it on that cycle.
// found is low and inverse is 0 when no inverse exists, which includes a
// modulus of 0 or 1 and any value sharing a factor with the modulus.
// All quotients come from one shared compare/subtract unit working as a
// restoring divider: the divisor is doubled one bit per cycle until aligned,
// then one quotient bit is taken per cycle on the way down. For 16-bit
// operands busy stays high for the shortest time with a modulus below 2 and
// longest with a Fibonacci-like value and modulus near 2^16 (22 Euclid
// steps). The next value is taken at the edge that ends the first cycle
// with busy low.
// The modulus sits behind an APB port at byte address 0; write it only
// while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module modular_inverse_search import mis_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [APB_ADDR_W-1:0]        paddr,
  input  wire logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]             prdata,
  output logic                              pready,
  // command
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] a_value,
  // result
  output logic                              done,
  output logic [DATA_WIDTH-1:0]             inverse,
  output logic                              found
);

  logic [DATA_WIDTH-1:0] modulus;

  // Register slice: hold the modulus for the sequencer.
  mis_cfg #(.DATA_WIDTH(DATA_WIDTH)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .modulus (modulus)
  );

  // Reduction and Euclid loop around the shared divide-step unit.
  mis_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .a_value (a_value),
    .modulus (modulus),
    .busy    (busy),
    .done    (done),
    .inverse (inverse),
    .found   (found)
  );

  // An accepted beat starts the work.
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  // The result beat ends the work and lasts one cycle.
  `ASSERT_NEXT(a_done_idle, clk, rst, done, !busy && !done)
  // No inverse reads as zero.
  `ASSERT_IMPLIES(a_miss_zero, clk, rst, done && !found, inverse == '0)
  // A found inverse lies in 1 .. modulus-1.
  `ASSERT_IMPLIES(a_hit_range, clk, rst, done && found, (inverse != '0) && (inverse < modulus))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the modular inverse block: directed and random
// values under several moduli, each result beat checked against a predictor.
// ----------------------------------------------------------------------------
module testbench;
  import mis_pkg::*;

  localparam int DW               = DATA_WIDTH_DEF;
  // Allow for the slowest item plus sender gaps and config.
  localparam int STALL_LIMIT      = 4000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 200;
  localparam int ITEMS_PER_PHASE  = 120;
  localparam int MAX_BURST        = 24;
  localparam int MAX_GAP          = 15;

  typedef struct {
    logic [DW-1:0] inverse;
    logic          found;
  } inverse_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the inverse of each accepted value under the modulus
  // currently programmed, and checks result beats in order against it.
  // --------------------------------------------------------------------------
  class inverse_scoreboard;
    bit [DW-1:0]   modulus;
    inverse_beat_t pending_answers[$];
    int unsigned   errors;

    function new();
      modulus = MODULUS_RESET;
      errors  = 0;
    endfunction

    // Reduce into 0 .. m-1, then run extended Euclid on (m, value).
    function inverse_beat_t predict_inverse(logic signed [DW-1:0] v);
      inverse_beat_t beat;
      longint m, rem_hi, rem_lo, co_hi, co_lo, quot, tmp;
      beat.inverse = '0;
      beat.found   = 1'b0;
      m = longint'(modulus);
      if (m >= 2) begin
        rem_lo = longint'(v) % m;
        if (rem_lo < 0) rem_lo += m;
        rem_hi = m;
        co_hi  = 0;
        co_lo  = 1;
        while (rem_lo != 0) begin
          quot   = rem_hi / rem_lo;
          tmp    = rem_hi - quot * rem_lo;
          rem_hi = rem_lo;
          rem_lo = tmp;
          tmp    = co_hi - quot * co_lo;
          co_hi  = co_lo;
          co_lo  = tmp;
        end
        // A gcd other than one means the value shares a factor with m.
        if (rem_hi == 1) begin
          co_hi = co_hi % m;
          if (co_hi < 0) co_hi += m;
          beat.inverse = co_hi[DW-1:0];
          beat.found   = 1'b1;
        end
      end
      return beat;
    endfunction

    function void note_value(logic signed [DW-1:0] v);
      pending_answers.push_back(predict_inverse(v));
    endfunction

    function void check_answer(logic [DW-1:0] inv, logic fnd);
      inverse_beat_t want;
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing outstanding: inverse=%0d found=%0b", inv, fnd);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (inv !== want.inverse) begin
        $error("inverse mismatch: expected %0d, actual %0d", want.inverse, inv);
        errors++;
      end
      if (fnd !== want.found) begin
        $error("found mismatch: expected %0b, actual %0b", want.found, fnd);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input holds a known value from time 0.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  start   = 1'b0;
  logic                  busy;
  logic signed [DW-1:0]  a_value = '0;

  logic                  done;
  logic [DW-1:0]         inverse;
  logic                  found;

  inverse_scoreboard sb;
  int unsigned       stall_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  modular_inverse_search #(
    .DATA_WIDTH (DW)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .a_value (a_value),
    .done    (done),
    .inverse (inverse),
    .found   (found)
  );

  // --------------------------------------------------------------------------
  // Result monitor: done lasts one cycle and cannot be held off, so capture
  // the beat on the edge that ends it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_answer(inverse, found);
    end
  end

  // Count cycles in which neither a command nor a result beat moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: end the run if the block goes quiet for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present a value and hold start until the block takes it (start high,
  // busy low at the edge). Leave start high so a back-to-back beat follows.
  task automatic send_value(input logic signed [DW-1:0] v);
    start   <= 1'b1;
    a_value <= v;
    do @(posedge clk); while (busy);
    sb.note_value(v);
  endtask

  // Drop start for a gap whose length is n; a zero gap keeps the burst going.
  task automatic pause_sender(input int unsigned n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding answer has come back and
  // the block has settled.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (sb.pending_answers.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase APB write of the modulus register; call only while idle.
  task automatic write_modulus(input bit [DW-1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MODULUS;
    pwdata  <= APB_DATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.modulus = m;
  endtask

  // Mostly uniform values, with a share aimed at the interesting corners:
  // small magnitudes, multiples of the modulus, the range ends and values
  // either side of the modulus.
  function automatic logic signed [DW-1:0] pick_value(input int unsigned m);
    int v;
    int k;
    case ($urandom_range(0, 9))
      6: v = int'($urandom_range(0, 64)) * ($urandom_range(0, 1) ? 1 : -1);
      7: begin
        if (m == 0) begin
          v = 0;
        end else begin
          k = int'($urandom_range(0, 32767 / m));
          v = $urandom_range(0, 1) ? k * int'(m) : -(k * int'(m));
        end
      end
      8: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      9: begin
        v = int'(m) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = int'($urandom);
    endcase
    return v[DW-1:0];
  endfunction

  // Random values in bursts of random length with random gaps; drain once
  // halfway through so the sender also waits on an empty pipeline.
  task automatic run_random_phase(input int unsigned count);
    int unsigned burst_left;
    int unsigned i;
    burst_left = $urandom_range(1, MAX_BURST);
    for (i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_drain();
      send_value(pick_value(sb.modulus));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, MAX_BURST);
        // Leave some bursts joined up so long stretches run with no gap.
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, MAX_GAP));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Directed values under the reset modulus of 26: zero, the range ends,
  // multiples of the modulus, values sharing a factor, negatives and
  // ordinary coprime values.
  int directed_values[] = '{0, 1, -1, 32767, -32768, 26, -26, 52, 13, -13, 2, 4,
                            3, 5, 7, -7, 25, -25, 27, 11, 17, 19, 23, 32761};

  // Moduli for the random phases: zero and one (no inverse possible), the
  // extremes, primes, powers of two and a few picked at random.
  int unsigned phase_moduli[] = '{1, 0, 65535, 2, 3, 65521, 32768, 7, 4096, 1000,
                                  65534, 26, 0, 0, 0, 0};

  initial begin
    sb = new();
    // Fill the last four phases with random moduli, one of them small.
    phase_moduli[12] = $urandom_range(2, 64);
    phase_moduli[13] = $urandom_range(2, 65535);
    phase_moduli[14] = $urandom_range(2, 65535);
    phase_moduli[15] = $urandom_range(256, 65535);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_values[i]) begin
      send_value(directed_values[i][DW-1:0]);
    end
    wait_for_drain();

    foreach (phase_moduli[i]) begin
      write_modulus(phase_moduli[i][DW-1:0]);
      run_random_phase(ITEMS_PER_PHASE);
      wait_for_drain();
    end

    // Allow any stray beat to show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
